/* hdl/wsd_pkg.sv */
package wsd_pkg;

    // Width kept for the decoded payload length and the payload counter.
    localparam int LENGTH_BITS = 32;

    // Widths of the result fields.
    localparam int PAYLOAD_LEN_W = 32;
    localparam int M_TDATA_W     = 48;
    localparam int M_TUSER_W     = 2;

    // Frame header constants.
    localparam logic [3:0] OP_CLOSE      = 4'h8;
    localparam logic [3:0] OP_PONG       = 4'hA;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } kind_t;

    // One result item as it moves from the parser to the output register.
    typedef struct packed {
        kind_t                      kind;
        logic [7:0]                 data_byte;
        logic [3:0]                 opcode;
        logic                       fin_flag;
        logic                       masked_flag;
        logic [PAYLOAD_LEN_W-1:0]   payload_length;
        logic                       last_of_frame;
    } wsd_result_t;

endpackage

/* hdl/wsd_parser.sv */
module wsd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          rx_byte,
    input  logic                buffer_last,
    output logic                res_valid,
    output wsd_pkg::wsd_result_t res
);
    import wsd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             header_count_reg, header_count_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   fin_reg, fin_next;
    logic                   masked_reg, masked_next;
    logic [6:0]             short_len_reg, short_len_next;
    logic [LENGTH_BITS-1:0] frame_len_reg, frame_len_next;
    logic [31:0]            mask_key_reg, mask_key_next;
    logic [LENGTH_BITS-1:0] payload_count_reg, payload_count_next;

    // Step flags handed from the next-state logic to the result logic.
    logic                   do_header;
    logic                   header_last;
    logic                   do_payload;
    logic                   payload_last;
    logic                   do_trunc;
    logic [7:0]             key_byte;

    // Next state of the parser and its header fields.
    always_comb begin
        logic [3:0]             hc_inc;
        logic [LENGTH_BITS-1:0] pc_inc;
        logic [3:0]             need;
        phase_t                 phase_pre;
        hc_inc = header_count_reg + 4'd1;
        pc_inc = payload_count_reg + 1'b1;
        need   = (short_len_reg == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;

        phase_pre          = phase_reg;
        header_count_next  = header_count_reg;
        opcode_next        = opcode_reg;
        fin_next           = fin_reg;
        masked_next        = masked_reg;
        short_len_next     = short_len_reg;
        frame_len_next     = frame_len_reg;
        mask_key_next      = mask_key_reg;
        payload_count_next = payload_count_reg;
        do_header          = 1'b0;
        header_last        = 1'b0;
        do_payload         = 1'b0;
        payload_last       = 1'b0;
        do_trunc           = 1'b0;

        unique case (phase_reg)
            PH_FIRST: begin
                fin_next           = rx_byte[7];
                opcode_next        = rx_byte[3:0];
                masked_next        = 1'b0;
                short_len_next     = '0;
                frame_len_next     = '0;
                mask_key_next      = '0;
                payload_count_next = '0;
                header_count_next  = '0;
                phase_pre          = PH_SECOND;
            end
            PH_SECOND: begin
                masked_next       = rx_byte[7];
                short_len_next    = rx_byte[6:0];
                header_count_next = '0;
                if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
                    frame_len_next = '0;
                    phase_pre      = PH_EXT;
                end else begin
                    frame_len_next = LENGTH_BITS'(rx_byte[6:0]);
                    if (rx_byte[7]) begin
                        phase_pre = PH_KEY;
                    end else begin
                        do_header = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                // Big-endian length bytes shift in from the bottom.
                frame_len_next    = {frame_len_reg[LENGTH_BITS-9:0], rx_byte};
                header_count_next = hc_inc;
                if (hc_inc >= need) begin
                    header_count_next = '0;
                    if (masked_reg) begin
                        phase_pre = PH_KEY;
                    end else begin
                        do_header = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                case (header_count_reg[1:0])
                    2'd0:    mask_key_next[7:0]   = mask_key_reg[7:0]   | rx_byte;
                    2'd1:    mask_key_next[15:8]  = mask_key_reg[15:8]  | rx_byte;
                    2'd2:    mask_key_next[23:16] = mask_key_reg[23:16] | rx_byte;
                    default: mask_key_next[31:24] = mask_key_reg[31:24] | rx_byte;
                endcase
                header_count_next = hc_inc;
                if (hc_inc >= KEY_BYTES) begin
                    do_header = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                payload_count_next = pc_inc;
                do_payload         = 1'b1;
                payload_last       = (pc_inc >= frame_len_reg);
                if (pc_inc >= frame_len_reg) begin
                    phase_pre = PH_FIRST;
                end
            end
            PH_SKIP: begin
                payload_count_next = pc_inc;
                if (pc_inc >= frame_len_reg) begin
                    phase_pre = PH_FIRST;
                end
            end
            default: begin
                phase_pre = PH_FIRST;
            end
        endcase

        // Header complete: pick the payload handling for this frame.
        if (do_header) begin
            payload_count_next = '0;
            header_count_next  = '0;
            if (frame_len_next == '0) begin
                phase_pre   = PH_FIRST;
                header_last = 1'b1;
            end else if (opcode_reg == OP_CLOSE || opcode_reg == OP_PONG) begin
                phase_pre   = PH_SKIP;
                header_last = 1'b1;
            end else begin
                phase_pre   = PH_PAYLOAD;
            end
        end

        // A buffer that ends inside a frame aborts it.
        phase_next = phase_pre;
        if (buffer_last && phase_pre != PH_FIRST) begin
            do_trunc           = 1'b1;
            phase_next         = PH_FIRST;
            header_count_next  = '0;
            payload_count_next = '0;
        end
    end

    // Key byte for the current payload position.
    always_comb begin
        case (payload_count_reg[1:0])
            2'd0:    key_byte = mask_key_reg[7:0];
            2'd1:    key_byte = mask_key_reg[15:8];
            2'd2:    key_byte = mask_key_reg[23:16];
            default: key_byte = mask_key_reg[31:24];
        endcase
    end

    // Result of this step, built from the updated frame fields.
    always_comb begin
        res.opcode         = opcode_next;
        res.fin_flag       = fin_next;
        res.masked_flag    = masked_next;
        res.payload_length = PAYLOAD_LEN_W'(frame_len_next);
        res.kind           = KIND_HEADER;
        res.data_byte      = '0;
        res.last_of_frame  = 1'b0;
        res_valid          = 1'b0;
        if (do_trunc) begin
            res_valid         = 1'b1;
            res.kind          = KIND_TRUNC;
            res.last_of_frame = 1'b1;
        end else if (do_header) begin
            res_valid         = 1'b1;
            res.kind          = KIND_HEADER;
            res.last_of_frame = header_last;
        end else if (do_payload) begin
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.data_byte     = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
            res.last_of_frame = payload_last;
        end
    end

    // Parser state registers, updated on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_FIRST;
            header_count_reg  <= '0;
            opcode_reg        <= '0;
            fin_reg           <= 1'b0;
            masked_reg        <= 1'b0;
            short_len_reg     <= '0;
            frame_len_reg     <= '0;
            mask_key_reg      <= '0;
            payload_count_reg <= '0;
        end else if (in_accept) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            opcode_reg        <= opcode_next;
            fin_reg           <= fin_next;
            masked_reg        <= masked_next;
            short_len_reg     <= short_len_next;
            frame_len_reg     <= frame_len_next;
            mask_key_reg      <= mask_key_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // The header byte counter never reaches the long length form's size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg < EXT64_BYTES)
        else $error("header byte counter out of range");

    // A truncation error always returns the parser to the frame start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && res_valid && res.kind == KIND_TRUNC) |=>
        (phase_reg == PH_FIRST && payload_count_reg == '0))
        else $error("parser did not resynchronize after truncation");

    // Skipped payload bytes produce nothing unless the buffer ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP && !buffer_last) |-> !res_valid)
        else $error("result produced for a skipped payload byte");

    // The last payload byte of a frame closes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && res_valid && res.kind == KIND_PAYLOAD && res.last_of_frame) |=>
        phase_reg == PH_FIRST)
        else $error("frame not closed after its last payload byte");

endmodule

/* hdl/wsd_out_reg.sv */
module wsd_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  wsd_pkg::wsd_result_t in_result,
    output logic                 in_ready,
    output logic                 out_valid,
    output wsd_pkg::wsd_result_t out_result,
    input  logic                 out_ready
);
    import wsd_pkg::*;

    logic        valid_reg, valid_next;
    wsd_result_t result_reg;

    // A new request may enter when the register is empty or drains now.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded only when a result enters.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // A waiting result blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while a result is stalled");

    // A result that is taken with nothing behind it leaves the register empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && out_ready && !in_valid) |=> !valid_reg)
        else $error("result repeated after it was taken");

    // A new result always occupies the register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && in_valid) |=> valid_reg)
        else $error("result lost on entry");

endmodule

/* hdl/websocket_frame_deframer_unit.sv */
// WebSocket receive-side frame deframer.
// The slave stream takes one received byte per request: s_axis_tdata holds the
// byte and s_axis_tlast marks the last byte of a receive buffer. The master
// stream returns results: a header result when the frame header is complete,
// one result per unmasked payload byte, or a truncation error when a buffer
// ends inside a frame. Payload bytes of close and pong frames give no result.
// m_axis_tuser carries the result kind and m_axis_tlast marks the final result
// of a frame.
// The result of an accepted byte is registered and valid in the cycle after.
// Throughput is one byte per cycle unless the receiver stalls, set by the
// single pass through the parser state update into the output register.
// Reset (aresetn low, synchronous) returns the parser to waiting for a first
// header byte with all frame fields zero and empties the output register.
// When the receiver stalls with a result waiting, s_axis_tready drops in the
// same cycle and returns as soon as that result is taken.
module websocket_frame_deframer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // rx_byte
    input  logic                           s_axis_tlast,  // buffer_last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // data_byte[7:0], opcode[11:8], fin_flag[12], masked_flag[13],
    // payload_length[45:14], zero fill[47:46]
    output logic [wsd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [wsd_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // kind[1:0]
    output logic                           m_axis_tlast   // last_of_frame
);
    import wsd_pkg::*;

    logic        in_accept;
    logic        res_valid;
    wsd_result_t res;
    wsd_result_t out_result;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    wsd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_axis_tdata),
        .buffer_last (s_axis_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_accept && res_valid),
        .in_result  (res),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_result (out_result),
        .out_ready  (m_axis_tready)
    );

    // Pack the result onto the master stream.
    assign m_axis_tdata = {2'b00,
                           out_result.payload_length,
                           out_result.masked_flag,
                           out_result.fin_flag,
                           out_result.opcode,
                           out_result.data_byte};
    assign m_axis_tuser = out_result.kind;
    assign m_axis_tlast = out_result.last_of_frame;

endmodule
